// ===== src/point_in_box_region_trigger_core_macros.svh =====
// assertion macros for the point-in-box region trigger core
// used by the top level only, expects clk and rst_n in scope
`ifndef POINT_IN_BOX_REGION_TRIGGER_CORE_MACROS_SVH
`define POINT_IN_BOX_REGION_TRIGGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PIBRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pibrt assertion failed");
`define PIBRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pibrt assertion failed");
`define PIBRT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pibrt assertion failed");
`else
`define PIBRT_ASSERT_IMPL(lbl, ante, cons)
`define PIBRT_ASSERT_NEXT(lbl, ante, cons)
`define PIBRT_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/pibrt_pkg.sv =====
// shared types and constants for the point-in-box region trigger
// no dependencies
package pibrt_pkg;

  localparam int COORD_W = 32;
  localparam int ENTRY_W = 7;
  localparam int COUNT_W = 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } pibrt_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] z_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_high;
    logic signed [COORD_W-1:0] z_high;
  } pibrt_box_t;

  typedef struct packed {
    logic               inside_any;
    logic [ENTRY_W-1:0] spot_index;
    logic               fire;
  } pibrt_result_t;

  typedef struct packed {
    logic clearing;
    logic walking;
    logic flag_we;
  } pibrt_status_t;

endpackage

// ===== src/pibrt_in_if.sv =====
// input channel: load or query beat with valid/ready
// depends on pibrt_pkg
interface pibrt_in_if import pibrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [ENTRY_W-1:0]        entry_index;
  logic signed [COORD_W-1:0] box_x_low;
  logic signed [COORD_W-1:0] box_y_low;
  logic signed [COORD_W-1:0] box_z_low;
  logic signed [COORD_W-1:0] box_x_high;
  logic signed [COORD_W-1:0] box_y_high;
  logic signed [COORD_W-1:0] box_z_high;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (
    output valid, func, entry_index, box_x_low, box_y_low, box_z_low,
           box_x_high, box_y_high, box_z_high, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, box_x_low, box_y_low, box_z_low,
           box_x_high, box_y_high, box_z_high, point_x, point_y, point_z,
    output ready
  );
endinterface

// ===== src/pibrt_out_if.sv =====
// result channel: one beat per accepted input beat
// depends on pibrt_pkg
interface pibrt_out_if import pibrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               inside_any;
  logic [ENTRY_W-1:0] spot_index;
  logic               fire;

  modport source (
    output valid, inside_any, spot_index, fire,
    input  ready
  );
  modport sink (
    input  valid, inside_any, spot_index, fire,
    output ready
  );
endinterface

// ===== src/pibrt_box_mem.sv =====
// box bound memory, one write port and one registered read port
// depends on pibrt_pkg
module pibrt_box_mem import pibrt_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pibrt_box_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output pibrt_box_t    rdata
);

  pibrt_box_t mem [DEPTH];
  pibrt_box_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pibrt_flag_mem.sv =====
// fired flag memory, one write port and one registered read port
// no dependencies; cleared by a sweep from the walker after reset
module pibrt_flag_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pibrt_walker.sv =====
// sequencer: flag clear sweep, box walk with flag read-modify-write, result register
// depends on pibrt_pkg, pibrt_in_if, pibrt_out_if
module pibrt_walker import pibrt_pkg::*; #(
  parameter int SPOTS = 128,
  parameter int IDX_W = 7,
  parameter int CNT_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  pibrt_in_if.sink          in_ch,
  pibrt_out_if.source       out_ch,
  input  logic [CNT_W-1:0]  limit,
  input  pibrt_box_t        box_rd,
  input  logic              flag_rd,
  output logic              rd_en,
  output logic [IDX_W-1:0]  rd_addr,
  output logic              flag_we,
  output logic [IDX_W-1:0]  flag_waddr,
  output logic              flag_wdata,
  output pibrt_status_t     status
);

  pibrt_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]          limit_r, limit_nxt;
  logic                      eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]          eval_idx_r, eval_idx_nxt;
  logic [IDX_W-1:0]          clr_idx_r, clr_idx_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic signed [COORD_W-1:0] pz_r, pz_nxt;
  pibrt_result_t             res_r, res_nxt;
  logic                      out_vld_r, out_vld_nxt;
  pibrt_result_t             out_res_r, out_res_nxt;
  logic                      slot_free;
  logic                      in_rdy;
  logic                      hit;

  // strict containment on all three axes
  assign hit = (px_r > box_rd.x_low) && (px_r < box_rd.x_high) &&
               (py_r > box_rd.y_low) && (py_r < box_rd.y_high) &&
               (pz_r > box_rd.z_low) && (pz_r < box_rd.z_high);

  assign slot_free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      eval_vld_r <= 1'b0;
      clr_idx_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= eval_vld_nxt;
      clr_idx_r  <= clr_idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    limit_r    <= limit_nxt;
    eval_idx_r <= eval_idx_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    limit_nxt    = limit_r;
    eval_vld_nxt = 1'b0;
    eval_idx_nxt = eval_idx_r;
    clr_idx_nxt  = clr_idx_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pz_nxt       = pz_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_res_nxt  = out_res_r;
    in_rdy       = 1'b0;
    rd_en        = 1'b0;
    flag_we      = 1'b0;
    flag_waddr   = eval_idx_r;
    flag_wdata   = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_idx_r;
        if (clr_idx_r == IDX_W'(SPOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        // a query may start while the previous result still waits
        in_rdy = (in_ch.func == FUNC_QUERY) || slot_free;
        if (in_ch.valid && in_rdy) begin
          if (in_ch.func == FUNC_QUERY) begin
            px_nxt     = in_ch.point_x;
            py_nxt     = in_ch.point_y;
            pz_nxt     = in_ch.point_z;
            limit_nxt  = limit;
            rd_idx_nxt = '0;
            state_nxt  = ST_WALK;
          end else begin
            out_vld_nxt = 1'b1;
            out_res_nxt = '0;
          end
        end
      end
      ST_WALK: begin
        if (rd_idx_r < limit_r) begin
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          eval_vld_nxt = 1'b1;
          eval_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        // flag write trails the read by one entry, so no same-entry overlap
        if (eval_vld_r) begin
          flag_we    = 1'b1;
          flag_wdata = hit;
          if (hit) begin
            res_nxt.inside_any = 1'b1;
            res_nxt.spot_index = ENTRY_W'({{ENTRY_W{1'b0}}, eval_idx_r});
            res_nxt.fire       = !flag_rd;
            state_nxt          = ST_FINISH;
          end
        end else if (rd_idx_r >= limit_r) begin
          res_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = res_r;
          state_nxt   = ST_IDLE;
        end
      end
    endcase
  end

  assign rd_addr = rd_idx_r[IDX_W-1:0];

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = out_vld_r;
  assign out_ch.inside_any = out_res_r.inside_any;
  assign out_ch.spot_index = out_res_r.spot_index;
  assign out_ch.fire       = out_res_r.fire;

  assign status.clearing = (state_r == ST_CLEAR);
  assign status.walking  = (state_r == ST_WALK);
  assign status.flag_we  = flag_we;

endmodule

// ===== src/point_in_box_region_trigger_core.sv =====
// top level of the point-in-box region trigger
// depends on pibrt_pkg, pibrt_in_if, pibrt_out_if, pibrt_box_mem, pibrt_flag_mem,
// pibrt_walker and point_in_box_region_trigger_core_macros.svh
//
// Keeps SPOTS axis-aligned boxes (signed Q16.16 bounds) in a box memory and one fired
// flag per box in a flag memory. A load beat writes one box (indexes at or above SPOTS
// are dropped) and returns an all-zero result in the next cycle. A query beat walks boxes
// 0 to min(spot_count, SPOTS)-1 at one box read per cycle, clears the flag of every box
// it passes and stops at the first box that holds the point strictly inside; the result
// gives its index, and fire is set when that box's flag was clear (the flag is then set).
// The walk is paced by the single read port of the box memory. After reset the flag
// memory is swept to zero, and no beat is accepted during the sweep. Write spot_count
// only while idle.
`include "point_in_box_region_trigger_core_macros.svh"

module point_in_box_region_trigger_core import pibrt_pkg::*; #(
  parameter int SPOTS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  pibrt_in_if.sink           in_ch,
  pibrt_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (SPOTS > 1) ? $clog2(SPOTS) : 1;
  localparam int CNT_W = $clog2(SPOTS + 1);

  logic [COUNT_W-1:0] spot_count_r, spot_count_nxt;
  logic [CNT_W-1:0]   limit;
  logic               box_we;
  pibrt_box_t         box_wdata;
  pibrt_box_t         box_rd;
  logic               flag_rd;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               flag_we;
  logic [IDX_W-1:0]   flag_waddr;
  logic               flag_wdata;
  pibrt_status_t      status;

  assign spot_count_nxt = cfg_we ? cfg_wdata : spot_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_count_r <= '0;
    end else begin
      spot_count_r <= spot_count_nxt;
    end
  end

  // saturate the count at the table depth
  assign limit = (32'(spot_count_r) > 32'(SPOTS)) ? CNT_W'(SPOTS) : CNT_W'(spot_count_r);

  assign box_we = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_LOAD) &&
                  (32'(in_ch.entry_index) < 32'(SPOTS));

  assign box_wdata.x_low  = in_ch.box_x_low;
  assign box_wdata.y_low  = in_ch.box_y_low;
  assign box_wdata.z_low  = in_ch.box_z_low;
  assign box_wdata.x_high = in_ch.box_x_high;
  assign box_wdata.y_high = in_ch.box_y_high;
  assign box_wdata.z_high = in_ch.box_z_high;

  pibrt_box_mem #(
    .DEPTH (SPOTS),
    .AW    (IDX_W)
  ) u_box_mem (
    .clk   (clk),
    .we    (box_we),
    .waddr (IDX_W'(in_ch.entry_index)),
    .wdata (box_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (box_rd)
  );

  pibrt_flag_mem #(
    .DEPTH (SPOTS),
    .AW    (IDX_W)
  ) u_flag_mem (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (flag_rd)
  );

  pibrt_walker #(
    .SPOTS (SPOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .limit      (limit),
    .box_rd     (box_rd),
    .flag_rd    (flag_rd),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .flag_we    (flag_we),
    .flag_waddr (flag_waddr),
    .flag_wdata (flag_wdata),
    .status     (status)
  );

  `PIBRT_ASSERT_NEVER(a_no_beat_in_clear, status.clearing && in_ch.ready)
  `PIBRT_ASSERT_NEXT(a_query_starts_walk, in_ch.valid && in_ch.ready && (in_ch.func == FUNC_QUERY), status.walking)
  `PIBRT_ASSERT_IMPL(a_flag_write_owner, status.flag_we, status.clearing || status.walking)
  `PIBRT_ASSERT_IMPL(a_miss_is_zero, out_ch.valid && !out_ch.inside_any, (out_ch.spot_index == '0) && !out_ch.fire)

endmodule
